@@ rtl/pofc_pkg.sv @@
package pofc_pkg;

  localparam int FLOW_W  = 6;
  localparam int ORDER_W = 32;
  localparam int LEN_W   = 14;
  localparam int CNT_W   = 48;

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] HDR_BYTES = CNT_W'(24);
  localparam logic [ORDER_W-1:0] UNSEEN  = '0;

  // one packet descriptor as it travels from the front to the back
  typedef struct packed {
    logic [FLOW_W-1:0]  flow_id;
    logic [ORDER_W-1:0] order_num;
    logic [LEN_W-1:0]   payload_len;
    logic               in_range;
  } desc_t;

endpackage

@@ rtl/pofc_front.sv @@
module pofc_front import pofc_pkg::*; #(
  parameter int NUM_FLOWS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FLOW_W-1:0]  in_flow_id,
  input  logic [ORDER_W-1:0] in_order_num,
  input  logic [LEN_W-1:0]   in_payload_len,
  output logic               q_vld,
  output desc_t              q_head,
  input  logic               q_pop
);

  desc_t       slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  desc_t       in_desc;

  always_comb begin
    in_desc.flow_id     = in_flow_id;
    in_desc.order_num   = in_order_num;
    in_desc.payload_len = in_payload_len;
    in_desc.in_range    = (32'(in_flow_id) < 32'(NUM_FLOWS));
  end

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_vld    = (cnt_r != 2'd0);
  assign q_head   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    cnt_nxt    = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_desc;
    end
  end

endmodule

@@ rtl/pofc_back.sv @@
module pofc_back import pofc_pkg::*; #(
  parameter int NUM_FLOWS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_vld,
  input  desc_t              q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic               out_order_error,
  output logic [ORDER_W-1:0] out_expected_order,
  output logic [CNT_W-1:0]   out_byte_total
);

  // only flows reachable through the flow field get an entry
  localparam int TBL_DEPTH = (NUM_FLOWS < (1 << FLOW_W)) ? NUM_FLOWS : (1 << FLOW_W);
  localparam int AW        = $clog2(TBL_DEPTH);

  logic [ORDER_W-1:0] tbl_mem [TBL_DEPTH];
  logic [TBL_DEPTH-1:0] ent_vld_r;

  desc_t              ex_r;
  logic               ex_vld_r;
  logic [ORDER_W-1:0] rd_data_r;
  logic               fwd_vld_r;
  logic [AW-1:0]      fwd_idx_r;
  logic [ORDER_W-1:0] fwd_data_r;

  logic               halted_r, halted_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               out_vld_r;

  logic [AW-1:0]      ex_idx, hd_idx;
  logic               ex_go, ex_load;
  logic [ORDER_W-1:0] stored;
  logic               match, wr_en, wr_fire, acc;
  logic [ORDER_W-1:0] wr_data;
  logic [CNT_W:0]     sum;

  assign ex_idx = ex_r.flow_id[AW-1:0];
  assign hd_idx = q_head.flow_id[AW-1:0];

  assign ex_go   = ex_vld_r && (!out_vld_r || !out_stall);
  assign ex_load = q_vld && (!ex_vld_r || ex_go);
  assign q_pop   = ex_load;

  always_comb begin
    // a write at the edge that loaded this item is not in the read data
    if (!ex_r.in_range || !ent_vld_r[ex_idx]) begin
      stored = UNSEEN;
    end else if (fwd_vld_r && (fwd_idx_r == ex_idx)) begin
      stored = fwd_data_r;
    end else begin
      stored = rd_data_r;
    end

    match      = (stored == UNSEEN) || (stored == ex_r.order_num);
    wr_data    = ex_r.order_num + ORDER_W'(1);
    sum        = {1'b0, cnt_r} + (CNT_W+1)'(ex_r.payload_len) + {1'b0, HDR_BYTES};
    halted_nxt = halted_r;
    cnt_nxt    = cnt_r;
    wr_en      = 1'b0;
    acc        = 1'b0;
    if (!halted_r && ex_r.in_range) begin
      if (match) begin
        wr_en   = 1'b1;
        acc     = 1'b1;
        cnt_nxt = (sum > {1'b0, CNT_MAX}) ? CNT_MAX : sum[CNT_W-1:0];
      end else begin
        halted_nxt = 1'b1;
      end
    end
  end

  assign wr_fire = ex_go && wr_en;

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      tbl_mem[ex_idx] <= wr_data;
    end
    if (ex_load) begin
      rd_data_r <= tbl_mem[hd_idx];
      ex_r      <= q_head;
      fwd_idx_r <= ex_idx;
      fwd_data_r <= wr_data;
    end
    if (ex_go) begin
      out_accepted       <= acc;
      out_order_error    <= halted_nxt;
      out_expected_order <= stored;
      out_byte_total     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      ex_vld_r  <= 1'b0;
      fwd_vld_r <= 1'b0;
      halted_r  <= 1'b0;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (wr_fire) begin
        ent_vld_r[ex_idx] <= 1'b1;
      end
      if (ex_load) begin
        fwd_vld_r <= wr_fire;
      end
      if (ex_go) begin
        halted_r <= halted_nxt;
        cnt_r    <= cnt_nxt;
      end
      if (ex_load) begin
        ex_vld_r <= 1'b1;
      end else if (ex_go) begin
        ex_vld_r <= 1'b0;
      end
      if (ex_go) begin
        out_vld_r <= 1'b1;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_vld_r;

endmodule

@@ rtl/per_flow_order_checker_unit.sv @@
// An accepted item goes through the front queue, the compare stage and the output register to out_valid.
// Throughput: one item per cycle while out_stall is low; the expected-order table does one
// read-modify-write per item, with the previous item's write forwarded to the compare stage.
// Reset (synchronous, rst_n low) clears the table valid bits, the halt flag and the
// byte counter at once; the block takes items in the first cycle after reset.
module per_flow_order_checker_unit import pofc_pkg::*; #(
  parameter int NUM_FLOWS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [FLOW_W-1:0]  in_flow_id,
  input  logic [ORDER_W-1:0] in_order_num,
  input  logic [LEN_W-1:0]   in_payload_len,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_accepted,
  output logic               out_order_error,
  output logic [ORDER_W-1:0] out_expected_order,
  output logic [CNT_W-1:0]   out_byte_total
);

  logic  q_vld;
  logic  q_pop;
  desc_t q_head;

  pofc_front #(
    .NUM_FLOWS (NUM_FLOWS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_flow_id     (in_flow_id),
    .in_order_num   (in_order_num),
    .in_payload_len (in_payload_len),
    .q_vld          (q_vld),
    .q_head         (q_head),
    .q_pop          (q_pop)
  );

  pofc_back #(
    .NUM_FLOWS (NUM_FLOWS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_vld              (q_vld),
    .q_head             (q_head),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_accepted       (out_accepted),
    .out_order_error    (out_order_error),
    .out_expected_order (out_expected_order),
    .out_byte_total     (out_byte_total)
  );

endmodule

@@ tb/sv/tb.sv @@
module tb;
  import pofc_pkg::*;

  localparam int FLOWS       = 1 << FLOW_W;
  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 480;

  typedef struct {
    logic               accepted;
    logic               order_error;
    logic [ORDER_W-1:0] expected_order;
    logic [CNT_W-1:0]   byte_total;
  } verdict_t;

  // Tracks expected order per flow, halt flag and byte count; queues one verdict per packet.
  class flow_order_tracker;
    logic [ORDER_W-1:0] next_order [FLOWS];
    logic               halt_seen;
    logic [CNT_W-1:0]   bytes_passed;
    verdict_t           pending_verdicts[$];
    int                 bad_count;
    int                 reported;

    function new();
      foreach (next_order[i]) next_order[i] = UNSEEN;
      halt_seen    = 1'b0;
      bytes_passed = '0;
      bad_count    = 0;
      reported     = 0;
    endfunction

    function void take_packet(logic [FLOW_W-1:0] flow, logic [ORDER_W-1:0] order,
                              logic [LEN_W-1:0] len);
      verdict_t           v;
      logic [ORDER_W-1:0] want;
      logic [CNT_W:0]     sum;
      v.accepted       = 1'b0;
      v.expected_order = next_order[flow];
      if (!halt_seen) begin
        // an unseen flow adopts whatever order the packet carries
        want = (next_order[flow] == UNSEEN) ? order : next_order[flow];
        if (want != order) begin
          halt_seen = 1'b1;
        end else begin
          next_order[flow] = want + 1'b1;
          sum = {1'b0, bytes_passed} + (CNT_W+1)'(len) + (CNT_W+1)'(HDR_BYTES);
          bytes_passed = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
          v.accepted = 1'b1;
        end
      end
      v.order_error = halt_seen;
      v.byte_total  = bytes_passed;
      pending_verdicts.push_back(v);
    endfunction

    function void check_verdict(logic acc, logic err, logic [ORDER_W-1:0] exp_ord,
                                logic [CNT_W-1:0] total);
      verdict_t w;
      if (pending_verdicts.size() == 0) begin
        bad_count++;
        if (reported < 10) begin
          reported++;
          $display("unexpected item: acc=%0b err=%0b exp=%h bytes=%0d",
                   acc, err, exp_ord, total);
        end
      end else begin
        w = pending_verdicts.pop_front();
        if (acc !== w.accepted || err !== w.order_error ||
            exp_ord !== w.expected_order || total !== w.byte_total) begin
          bad_count++;
          if (reported < 10) begin
            reported++;
            $display("mismatch: got acc=%0b err=%0b exp=%h bytes=%0d", acc, err, exp_ord, total);
            $display("       wanted acc=%0b err=%0b exp=%h bytes=%0d",
                     w.accepted, w.order_error, w.expected_order, w.byte_total);
          end
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [FLOW_W-1:0]  in_flow_id;
  logic [ORDER_W-1:0] in_order_num;
  logic [LEN_W-1:0]   in_payload_len;
  logic               out_valid;
  logic               out_stall;
  logic               out_accepted;
  logic               out_order_error;
  logic [ORDER_W-1:0] out_expected_order;
  logic [CNT_W-1:0]   out_byte_total;

  flow_order_tracker tracker;
  int idle_pct;
  int stall_pct;
  int quiet_cycles;

  per_flow_order_checker_unit u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_flow_id         (in_flow_id),
    .in_order_num       (in_order_num),
    .in_payload_len     (in_payload_len),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_accepted       (out_accepted),
    .out_order_error    (out_order_error),
    .out_expected_order (out_expected_order),
    .out_byte_total     (out_byte_total)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      tracker.check_verdict(out_accepted, out_order_error, out_expected_order, out_byte_total);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("per_flow_order_checker_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_packet(logic [FLOW_W-1:0] flow, logic [ORDER_W-1:0] order,
                             logic [LEN_W-1:0] len);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_flow_id     <= flow;
    in_order_num   <= order;
    in_payload_len <= len;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.take_packet(flow, order, len);
    @(negedge clk);
  endtask

  // in-order packets: seen flows get their expected order, unseen flows a fresh start
  task automatic send_in_order(int n);
    logic [FLOW_W-1:0]  flow;
    logic [ORDER_W-1:0] order;
    logic [LEN_W-1:0]   len;
    repeat (n) begin
      // half the traffic on a few flows so back-to-back hits on one flow are common
      flow = $urandom_range(0, 1) ? FLOW_W'($urandom_range(0, 3))
                                  : FLOW_W'($urandom_range(0, FLOWS - 1));
      if (tracker.next_order[flow] != UNSEEN) begin
        order = tracker.next_order[flow];
      end else begin
        case ($urandom_range(0, 3))
          0: order = '1 - ORDER_W'($urandom_range(0, 4));
          1: order = ORDER_W'($urandom_range(0, 7));
          default: order = $urandom;
        endcase
      end
      case ($urandom_range(0, 7))
        0: len = '0;
        1: len = '1;
        default: len = LEN_W'($urandom_range(0, (1 << LEN_W) - 1));
      endcase
      send_packet(flow, order, len);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending_verdicts.size() != 0) @(negedge clk);
  endtask

  initial begin
    tracker        = new();
    idle_pct       = 0;
    stall_pct      = 0;
    quiet_cycles   = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_flow_id     = '0;
    in_order_num   = '0;
    in_payload_len = '0;
    out_stall      = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    send_packet(6'd0, 32'd0, '0);
    send_packet(6'd0, 32'd1, '1);
    send_packet(6'd0, 32'd2, 14'd1);
    // order wraps to zero: the flow is unseen again and adopts the next order
    send_packet(6'd63, 32'hFFFF_FFFF, '1);
    send_packet(6'd63, 32'hA5A5_A5A5, 14'd0);
    send_packet(6'd63, 32'hA5A5_A5A6, 14'd100);
    send_packet(6'd5, 32'hFFFF_FFFE, 14'h1FFF);
    send_packet(6'd5, 32'hFFFF_FFFF, 14'h2000);
    send_packet(6'd5, 32'd0, 14'd7);
    send_packet(6'd42, 32'h5A5A_5A5A, 14'h2AAA);
    send_packet(6'd21, 32'h8000_0000, 14'h1555);
    send_packet(6'd42, 32'h5A5A_5A5B, 14'h3FFE);
    send_packet(6'd0, 32'd3, 14'd24);

    send_in_order(PHASE_ITEMS);
    wait_drained();

    idle_pct = 56;
    send_in_order(PHASE_ITEMS);
    wait_drained();

    idle_pct  = 0;
    stall_pct = 56;
    send_in_order(PHASE_ITEMS);
    wait_drained();

    idle_pct  = 27;
    stall_pct = 27;
    send_in_order(PHASE_ITEMS);

    // wrong order on a seen flow right after a hit on it, then traffic while halted
    send_packet(6'd0, tracker.next_order[0], 14'd9);
    send_packet(6'd0, tracker.next_order[0] ^ ($urandom | 32'd1), 14'd9);
    repeat (40) begin
      send_packet(FLOW_W'($urandom_range(0, FLOWS - 1)), $urandom,
                  LEN_W'($urandom_range(0, (1 << LEN_W) - 1)));
    end
    wait_drained();
    repeat (10) @(negedge clk);

    if (tracker.bad_count == 0) begin
      $display("per_flow_order_checker_unit regression: pass");
    end else begin
      $display("per_flow_order_checker_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ per_flow_order_checker_unit.f @@
rtl/pofc_pkg.sv
rtl/pofc_front.sv
rtl/pofc_back.sv
rtl/per_flow_order_checker_unit.sv
tb/sv/tb.sv
